@@ hdl/tbl_pkg.sv @@
// ----------------------------------------------------------------------------
// tbl_pkg
// Shared types, codes and helpers for the tagged bank locator.
// ----------------------------------------------------------------------------
package tbl_pkg;

   localparam int WORD_BITS      = 32;
   localparam int CSR_INDEX_BITS = 3;
   localparam int BYTE_BITS      = 26;
   localparam int OUT_INDEX_BITS = 24;

   // register indexes of the configuration port
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAGMENT_TAG    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAGMENT_NUMBER = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MATCH_ANY       = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BANK_TAG        = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BANK_NUMBER     = 3'd4;

   // header type codes
   localparam logic [5:0] TYPE_FRAGMENT   = 6'h0e;
   localparam logic [5:0] TYPE_FRAGMENT_B = 6'h10;
   localparam logic [5:0] TYPE_COMPOSITE  = 6'h0f;

   localparam logic [BYTE_BITS-1:0] BYTES_MAX = {BYTE_BITS{1'b1}};

   typedef enum logic [1:0] {
      STATUS_MISS      = 2'd0,
      STATUS_PLAIN     = 2'd1,
      STATUS_COMPOSITE = 2'd2
   } status_type;

   typedef struct packed {
      logic [15:0] fragment_tag;
      logic [7:0]  fragment_number;
      logic        match_any_fragment_number;
      logic [15:0] bank_tag;
      logic [7:0]  bank_number;
   } cfg_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] event_word;
      logic                 last_word;
   } word_type;

   typedef struct packed {
      status_type                status;
      logic [OUT_INDEX_BITS-1:0] bank_index;
      logic [OUT_INDEX_BITS-1:0] data_index;
      logic [BYTE_BITS-1:0]      byte_count;
   } result_type;

   // clamp a signed byte count into the unsigned result range
   function automatic logic [BYTE_BITS-1:0] clamp_bytes(input logic signed [35:0] v);
      logic [BYTE_BITS-1:0] r;
      if (v[35]) begin
         r = '0;
      end else if (v[34:BYTE_BITS] != '0) begin
         r = BYTES_MAX;
      end else begin
         r = v[BYTE_BITS-1:0];
      end
      return r;
   endfunction

endpackage

@@ hdl/tbl_word_reg.sv @@
// ----------------------------------------------------------------------------
// tbl_word_reg
// Input register: holds one word until the search stage takes it.
// ----------------------------------------------------------------------------
module tbl_word_reg
   import tbl_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [WORD_BITS-1:0] req_event_word,
   input  logic                 req_last_word,
   input  logic                 advance,
   output logic                 word_valid,
   output word_type             word
);

   logic     valid_ff, valid_in;
   word_type word_ff, word_in;

   // refill in the same cycle the held word moves on
   assign req_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      word_in  = word_ff;
      if (advance) begin
         valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         valid_in           = 1'b1;
         word_in.event_word = req_event_word;
         word_in.last_word  = req_last_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end

   assign word_valid = valid_ff;
   assign word       = word_ff;

endmodule

@@ hdl/tbl_search.sv @@
// ----------------------------------------------------------------------------
// tbl_search
// Header walk state and its one-word update; builds the result on the last word.
// ----------------------------------------------------------------------------
module tbl_search
   import tbl_pkg::*;
#(
   parameter int INDEX_BITS = 24
)
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       step,
   input  word_type   word,
   output result_type result
);

   localparam int P  = INDEX_BITS + 1;
   localparam int DW = INDEX_BITS + 18;

   typedef enum logic [6:0] {
      PH_FRAG  = 7'b0000001,
      PH_BANK  = 7'b0000010,
      PH_SEG   = 7'b0000100,
      PH_INNER = 7'b0001000,
      PH_PLAIN = 7'b0010000,
      PH_COMP  = 7'b0100000,
      PH_MISS  = 7'b1000000
   } phase_type;

   logic [P-1:0]          pos_ff, pos_in;
   logic [P-1:0]          next_ff, next_in;
   logic [WORD_BITS-1:0]  event_words_ff, event_words_in;
   logic [WORD_BITS-1:0]  header_words_ff, header_words_in;
   phase_type             phase_ff, phase_in;
   logic [INDEX_BITS-1:0] frag_start_ff, frag_start_in;
   logic [WORD_BITS-1:0]  frag_words_ff, frag_words_in;
   logic [INDEX_BITS-1:0] bank_start_ff, bank_start_in;
   logic [WORD_BITS-1:0]  bank_words_ff, bank_words_in;
   logic [16:0]           seg_words_ff, seg_words_in;
   logic                  hdr_open_ff, hdr_open_in;
   logic [DW-1:0]         found_data_ff, found_data_in;
   logic [BYTE_BITS-1:0]  found_bytes_ff, found_bytes_in;

   logic [15:0]           w_tag;
   logic [5:0]            w_typ;
   logic [7:0]            w_num;
   logic [INDEX_BITS-1:0] p;
   logic                  open_miss;
   logic                  frag_type;
   logic                  frag_hit;
   logic                  bank_hit;
   logic [WORD_BITS-1:0]  step_words;
   logic [32:0]           sum;
   logic [P-1:0]          next_step;
   logic [DW-1:0]         inner_pos;
   logic [DW-1:0]         comp_data;
   logic [35:0]           plain_diff;
   logic [35:0]           comp_diff;
   logic [35:0]           comp_val;
   logic [INDEX_BITS+23:0] start_wide;

   assign w_tag = word.event_word[31:16];
   assign w_typ = word.event_word[13:8];
   assign w_num = word.event_word[7:0];
   assign p     = pos_ff[INDEX_BITS-1:0];

   // a header opened here would lie past the end of the event or fragment
   assign open_miss = (phase_ff == PH_FRAG) ?
      ({{(WORD_BITS-P){1'b0}}, pos_ff} >= event_words_ff) :
      ({{(WORD_BITS-INDEX_BITS){1'b0}}, p - frag_start_ff} >= frag_words_ff);

   assign frag_type = (w_typ == TYPE_FRAGMENT) || (w_typ == TYPE_FRAGMENT_B);
   assign frag_hit  = frag_type && (w_tag == cfg.fragment_tag) &&
                      ((w_num == cfg.fragment_number) || cfg.match_any_fragment_number);
   assign bank_hit  = (w_tag == cfg.bank_tag) && (w_num == cfg.bank_number);

   // skip nonmatching fragments by their header only, other headers by length
   assign step_words = ((phase_ff == PH_FRAG) && frag_type) ? WORD_BITS'(2) : header_words_ff;
   assign sum        = {{(33-P){1'b0}}, next_ff} + {1'b0, step_words};
   assign next_step  = (sum[32:INDEX_BITS] != '0) ? {1'b1, {INDEX_BITS{1'b0}}} :
                       sum[P-1:0];

   assign inner_pos = {{18{1'b0}}, bank_start_ff} + DW'(3) +
                      {{(DW-17){1'b0}}, seg_words_ff};
   assign comp_data = inner_pos + DW'(1);

   assign plain_diff = {4'b0, header_words_ff} - 36'd2;
   assign comp_diff  = {4'b0, bank_words_ff} - 36'd4 - {19'b0, seg_words_ff};
   assign comp_val   = {comp_diff[33:0], 2'b00} - {34'b0, word.event_word[15:14]};

   always_comb begin
      pos_in          = pos_ff;
      next_in         = next_ff;
      event_words_in  = event_words_ff;
      header_words_in = header_words_ff;
      phase_in        = phase_ff;
      frag_start_in   = frag_start_ff;
      frag_words_in   = frag_words_ff;
      bank_start_in   = bank_start_ff;
      bank_words_in   = bank_words_ff;
      seg_words_in    = seg_words_ff;
      hdr_open_in     = hdr_open_ff;
      found_data_in   = found_data_ff;
      found_bytes_in  = found_bytes_ff;

      if (step && !pos_ff[INDEX_BITS]) begin
         pos_in = pos_ff + P'(1);
         if (pos_ff == '0) begin
            event_words_in = word.event_word + WORD_BITS'(1);
         end else if (phase_ff == PH_FRAG || phase_ff == PH_BANK) begin
            if (hdr_open_ff && (next_ff + P'(1) == pos_ff)) begin
               hdr_open_in = 1'b0;
               if (phase_ff == PH_FRAG && frag_hit) begin
                  frag_start_in = next_ff[INDEX_BITS-1:0];
                  frag_words_in = header_words_ff;
                  if (header_words_ff <= WORD_BITS'(2)) begin
                     phase_in = PH_MISS;
                  end else begin
                     phase_in = PH_BANK;
                     next_in  = next_ff + P'(2);
                  end
               end else if (phase_ff == PH_BANK && bank_hit) begin
                  bank_start_in = next_ff[INDEX_BITS-1:0];
                  bank_words_in = header_words_ff;
                  if (w_typ != TYPE_COMPOSITE) begin
                     found_data_in  = {{(DW-P){1'b0}}, next_ff} + DW'(2);
                     found_bytes_in = clamp_bytes({plain_diff[33:0], 2'b00});
                     phase_in       = PH_PLAIN;
                  end else begin
                     phase_in = PH_SEG;
                  end
               end else begin
                  next_in = next_step;
                  // step of one: this word is the next header's length word
                  if (next_step == pos_ff) begin
                     if (open_miss) begin
                        phase_in = PH_MISS;
                     end else begin
                        header_words_in = word.event_word + WORD_BITS'(1);
                        hdr_open_in     = 1'b1;
                     end
                  end else if (next_step < pos_ff) begin
                     phase_in = PH_MISS;
                  end
               end
            end else if (!hdr_open_ff && (next_ff == pos_ff)) begin
               if (open_miss) begin
                  phase_in = PH_MISS;
               end else begin
                  header_words_in = word.event_word + WORD_BITS'(1);
                  hdr_open_in     = 1'b1;
               end
            end
         end else if (phase_ff == PH_SEG) begin
            if (pos_ff == {1'b0, bank_start_ff} + P'(2)) begin
               seg_words_in = {1'b0, word.event_word[15:0]} + 17'd1;
               phase_in     = PH_INNER;
            end
         end else if (phase_ff == PH_INNER) begin
            if ({{(DW-P){1'b0}}, pos_ff} == inner_pos) begin
               found_bytes_in = clamp_bytes(comp_val);
               found_data_in  = comp_data;
               phase_in       = PH_COMP;
            end
         end
      end

      // result from the state this word leaves behind
      start_wide = {{24{1'b0}}, bank_start_in};
      result     = '0;
      if (phase_in == PH_PLAIN || phase_in == PH_COMP) begin
         result.status     = (phase_in == PH_PLAIN) ? STATUS_PLAIN : STATUS_COMPOSITE;
         result.bank_index = start_wide[OUT_INDEX_BITS-1:0];
         result.data_index = found_data_in[OUT_INDEX_BITS-1:0];
         result.byte_count = found_bytes_in;
      end

      // drop the event state after its last word
      if (step && word.last_word) begin
         pos_in          = '0;
         next_in         = P'(2);
         event_words_in  = '0;
         header_words_in = '0;
         phase_in        = PH_FRAG;
         frag_start_in   = '0;
         frag_words_in   = '0;
         bank_start_in   = '0;
         bank_words_in   = '0;
         seg_words_in    = '0;
         hdr_open_in     = 1'b0;
         found_data_in   = '0;
         found_bytes_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff          <= '0;
         next_ff         <= P'(2);
         event_words_ff  <= '0;
         header_words_ff <= '0;
         phase_ff        <= PH_FRAG;
         frag_start_ff   <= '0;
         frag_words_ff   <= '0;
         bank_start_ff   <= '0;
         bank_words_ff   <= '0;
         seg_words_ff    <= '0;
         hdr_open_ff     <= 1'b0;
         found_data_ff   <= '0;
         found_bytes_ff  <= '0;
      end else begin
         pos_ff          <= pos_in;
         next_ff         <= next_in;
         event_words_ff  <= event_words_in;
         header_words_ff <= header_words_in;
         phase_ff        <= phase_in;
         frag_start_ff   <= frag_start_in;
         frag_words_ff   <= frag_words_in;
         bank_start_ff   <= bank_start_in;
         bank_words_ff   <= bank_words_in;
         seg_words_ff    <= seg_words_in;
         hdr_open_ff     <= hdr_open_in;
         found_data_ff   <= found_data_in;
         found_bytes_ff  <= found_bytes_in;
      end
   end

endmodule

@@ hdl/tagged_bank_locator.sv @@
// ----------------------------------------------------------------------------
// tagged_bank_locator
// Finds a bank by tag and number inside a fragment found by tag and number.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle, set by the single search update per word;
//   a last word stalls only while the previous result waits on rsp_ready.
// The result for an event shows on rsp_valid after its last word passes the
//   input register, then the result register.
// Reset: synchronous; clears the walk state, config and valid bits only.
// ----------------------------------------------------------------------------
module tagged_bank_locator
   import tbl_pkg::*;
#(
   parameter int INDEX_BITS = 24
)
(
   input  logic                      clock,
   input  logic                      reset,
   // input words
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [WORD_BITS-1:0]      req_event_word,
   input  logic                      req_last_word,
   // results
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [1:0]                rsp_status,
   output logic [OUT_INDEX_BITS-1:0] rsp_bank_index,
   output logic [OUT_INDEX_BITS-1:0] rsp_data_index,
   output logic [BYTE_BITS-1:0]      rsp_byte_count,
   // configuration writes
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [WORD_BITS-1:0]      csr_data
);

   cfg_type    cfg_ff, cfg_in;
   logic       word_valid;
   word_type   word;
   logic       advance;
   result_type result;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;

   // Registers are always writable; writes beyond the list are dropped.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_FRAGMENT_TAG:    cfg_in.fragment_tag              = csr_data[15:0];
            CSR_FRAGMENT_NUMBER: cfg_in.fragment_number           = csr_data[7:0];
            CSR_MATCH_ANY:       cfg_in.match_any_fragment_number = csr_data[0];
            CSR_BANK_TAG:        cfg_in.bank_tag                  = csr_data[15:0];
            CSR_BANK_NUMBER:     cfg_in.bank_number               = csr_data[7:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   // Advance the held word unless it is a last word and the result slot is
   // still occupied by a result nobody has taken yet.
   assign advance = word_valid && (!word.last_word || !rsp_valid_ff || rsp_ready);

   tbl_word_reg u_word_reg (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_event_word (req_event_word),
      .req_last_word  (req_last_word),
      .advance        (advance),
      .word_valid     (word_valid),
      .word           (word)
   );

   tbl_search #(
      .INDEX_BITS (INDEX_BITS)
   ) u_search (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .step   (advance),
      .word   (word),
      .result (result)
   );

   // Result register: load on a last word, hold until taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (advance && word.last_word) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_ff.status;
   assign rsp_bank_index = rsp_ff.bank_index;
   assign rsp_data_index = rsp_ff.data_index;
   assign rsp_byte_count = rsp_ff.byte_count;

endmodule

@@ dv/tb_tagged_bank_locator.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tagged_bank_locator
// Streams events word by word into the locator and checks every lookup result
// against a cycle-free model of the fragment and bank walk. A directed part
// covers the corner cases, then random events, mostly well formed, run under
// three idle patterns on both channels.
// ----------------------------------------------------------------------------
module tb_tagged_bank_locator;
   import tbl_pkg::*;

   localparam int INDEX_BITS   = 24;
   localparam int DRAIN_CYCLES = 8;
   localparam int REPORT_LIMIT = 10;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LAST_INDEX = '1;

   typedef logic [33:0] span_type;
   typedef bit [31:0] word_queue_type[$];

   typedef enum logic [2:0] {
      WALK_FRAGMENT,
      WALK_BANK,
      WALK_SEGMENT,
      WALK_INNER,
      WALK_PLAIN,
      WALK_COMPOSITE,
      WALK_MISS
   } walk_phase_type;

   localparam span_type POS_LIMIT = span_type'(1) << INDEX_BITS;

   logic                      clock          = 1'b0;
   logic                      reset          = 1'b1;
   logic                      req_valid      = 1'b0;
   logic                      req_ready;
   logic [WORD_BITS-1:0]      req_event_word = '0;
   logic                      req_last_word  = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready      = 1'b0;
   logic [1:0]                rsp_status;
   logic [OUT_INDEX_BITS-1:0] rsp_bank_index;
   logic [OUT_INDEX_BITS-1:0] rsp_data_index;
   logic [BYTE_BITS-1:0]      rsp_byte_count;
   logic                      csr_valid      = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index      = '0;
   logic [WORD_BITS-1:0]      csr_data       = '0;

   tagged_bank_locator #(.INDEX_BITS(INDEX_BITS)) dut (.*);

   always #1 clock = ~clock;

   // idle rates, in percent of cycles
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   int lookup_errors = 0;
   result_type pending_lookups[$];

   // model copy of the registers and of the walk state for the event in flight
   cfg_type        search_cfg = '0;
   span_type       walk_pos, event_len, next_hdr, hdr_len;
   span_type       frag_base, frag_len, bank_base, bank_len, seg_len;
   walk_phase_type walk_phase;
   logic           hdr_pending;
   span_type       hit_data;
   logic [BYTE_BITS-1:0] hit_bytes;

   // -------------------------------------------------------------------------
   // walk model
   // -------------------------------------------------------------------------
   function automatic void clear_walk();
      walk_pos    = '0;
      event_len   = '0;
      next_hdr    = 34'd2;
      hdr_len     = '0;
      walk_phase  = WALK_FRAGMENT;
      frag_base   = '0;
      frag_len    = '0;
      bank_base   = '0;
      bank_len    = '0;
      seg_len     = '0;
      hdr_pending = 1'b0;
      hit_data    = '0;
      hit_bytes   = '0;
   endfunction

   function automatic logic [BYTE_BITS-1:0] sat_bytes(input longint v);
      if (v < 0) return '0;
      if (v > longint'(BYTES_MAX)) return BYTES_MAX;
      return v[BYTE_BITS-1:0];
   endfunction

   // length words count the words that follow, so the span is length plus one, mod 2^32
   function automatic span_type span_of(input logic [31:0] w);
      logic [31:0] s;
      s = w + 32'd1;
      return span_type'(s);
   endfunction

   function automatic void open_header(input logic [31:0] w);
      if (walk_phase == WALK_FRAGMENT) begin
         if (next_hdr >= event_len) begin
            walk_phase = WALK_MISS;
            return;
         end
      end else if (next_hdr - frag_base >= frag_len) begin
         walk_phase = WALK_MISS;
         return;
      end
      hdr_len     = span_of(w);
      hdr_pending = 1'b1;
   endfunction

   // a step that lands on the current word opens it at once; one behind means stuck
   function automatic void after_step(input logic [31:0] w);
      hdr_pending = 1'b0;
      if (next_hdr == walk_pos) begin
         open_header(w);
      end else if (next_hdr < walk_pos) begin
         walk_phase = WALK_MISS;
      end
   endfunction

   function automatic void decode_header(input logic [31:0] w);
      logic [15:0] tag;
      logic [5:0]  kind;
      logic [7:0]  num;
      tag  = w[31:16];
      kind = w[13:8];
      num  = w[7:0];
      if (walk_phase == WALK_FRAGMENT) begin
         if (kind == TYPE_FRAGMENT || kind == TYPE_FRAGMENT_B) begin
            if (tag == search_cfg.fragment_tag &&
                (num == search_cfg.fragment_number || search_cfg.match_any_fragment_number)) begin
               frag_base   = next_hdr;
               frag_len    = hdr_len;
               hdr_pending = 1'b0;
               if (frag_len <= 2) begin
                  walk_phase = WALK_MISS;
               end else begin
                  walk_phase = WALK_BANK;
                  next_hdr   = frag_base + 2;
               end
               return;
            end
            // step into a fragment that does not match
            next_hdr = next_hdr + 2;
         end else begin
            next_hdr = next_hdr + hdr_len;
         end
         after_step(w);
         return;
      end
      if (tag == search_cfg.bank_tag && num == search_cfg.bank_number) begin
         bank_base   = next_hdr;
         bank_len    = hdr_len;
         hdr_pending = 1'b0;
         if (kind != TYPE_COMPOSITE) begin
            hit_data   = bank_base + 2;
            hit_bytes  = sat_bytes((longint'(bank_len) - 2) * 4);
            walk_phase = WALK_PLAIN;
         end else begin
            walk_phase = WALK_SEGMENT;
         end
         return;
      end
      next_hdr = next_hdr + hdr_len;
      after_step(w);
   endfunction

   // advance the model by one accepted word; queue a lookup result on the last one
   function automatic void track_event_word(input logic [31:0] w, input logic last);
      span_type   p;
      result_type r;
      p = walk_pos;
      if (p < POS_LIMIT) begin
         if (p == 0) begin
            event_len = span_of(w);
         end else if (walk_phase == WALK_FRAGMENT || walk_phase == WALK_BANK) begin
            if (hdr_pending && p == next_hdr + 1) begin
               decode_header(w);
            end else if (!hdr_pending && p == next_hdr) begin
               open_header(w);
            end
         end else if (walk_phase == WALK_SEGMENT) begin
            if (p == bank_base + 2) begin
               seg_len    = span_type'(w[15:0]) + 1;
               walk_phase = WALK_INNER;
            end
         end else if (walk_phase == WALK_INNER) begin
            if (p == bank_base + 3 + seg_len) begin
               hit_bytes  = sat_bytes((longint'(bank_len) - 4 - longint'(seg_len)) * 4
                                      - longint'(w[15:14]));
               hit_data   = bank_base + 4 + seg_len;
               walk_phase = WALK_COMPOSITE;
            end
         end
         walk_pos = p + 1;
      end
      if (!last) return;
      r = '0;
      if (walk_phase == WALK_PLAIN || walk_phase == WALK_COMPOSITE) begin
         if (walk_phase == WALK_PLAIN) begin
            r.status = STATUS_PLAIN;
         end else begin
            r.status = STATUS_COMPOSITE;
         end
         r.bank_index = bank_base[OUT_INDEX_BITS-1:0];
         r.data_index = hit_data[OUT_INDEX_BITS-1:0];
         r.byte_count = hit_bytes;
      end else begin
         r.status = STATUS_MISS;
      end
      pending_lookups.push_back(r);
      clear_walk();
   endfunction

   // -------------------------------------------------------------------------
   // result side: random back-pressure, compare each result with the oldest
   // expected lookup
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : rsp_monitor
      result_type want;
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_lookups.size() == 0) begin
            if (lookup_errors < REPORT_LIMIT)
               $display("unexpected lookup: status %0d bank %0d data %0d bytes %0d",
                        rsp_status, rsp_bank_index, rsp_data_index, rsp_byte_count);
            lookup_errors++;
         end else begin
            want = pending_lookups.pop_front();
            if (rsp_status !== want.status || rsp_bank_index !== want.bank_index ||
                rsp_data_index !== want.data_index || rsp_byte_count !== want.byte_count) begin
               if (lookup_errors < REPORT_LIMIT)
                  $display("lookup mismatch: want %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                           want.status, want.bank_index, want.data_index, want.byte_count,
                           rsp_status, rsp_bank_index, rsp_data_index, rsp_byte_count);
               lookup_errors++;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // drivers
   // -------------------------------------------------------------------------
   // Send one word. Valid stays high from the previous word unless an idle gap
   // is taken here, so it is never dropped and raised in the same step.
   task automatic send_word(input logic [31:0] w, input logic last);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid      <= 1'b1;
      req_event_word <= w;
      req_last_word  <= last;
      do @(posedge clock); while (!req_ready);
      track_event_word(w, last);
   endtask

   task automatic send_event(input word_queue_type words);
      for (int i = 0; i < words.size(); i++)
         send_word(words[i], i == words.size() - 1);
   endtask

   // drop valid, wait out all expected lookups, then let the pipeline empty
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_lookups.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // one register write; valid is then held low so it never toggles in one step
   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_FRAGMENT_TAG:    search_cfg.fragment_tag              = data[15:0];
         CSR_FRAGMENT_NUMBER: search_cfg.fragment_number           = data[7:0];
         CSR_MATCH_ANY:       search_cfg.match_any_fragment_number = data[0];
         CSR_BANK_TAG:        search_cfg.bank_tag                  = data[15:0];
         CSR_BANK_NUMBER:     search_cfg.bank_number               = data[7:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // write all registers; unused upper data bits carry noise
   task automatic load_config(input cfg_type c);
      logic [31:0] d;
      d = $urandom(); d[15:0] = c.fragment_tag;             write_csr(CSR_FRAGMENT_TAG, d);
      d = $urandom(); d[7:0]  = c.fragment_number;          write_csr(CSR_FRAGMENT_NUMBER, d);
      d = $urandom(); d[0]    = c.match_any_fragment_number; write_csr(CSR_MATCH_ANY, d);
      d = $urandom(); d[15:0] = c.bank_tag;                 write_csr(CSR_BANK_TAG, d);
      d = $urandom(); d[7:0]  = c.bank_number;              write_csr(CSR_BANK_NUMBER, d);
   endtask

   // -------------------------------------------------------------------------
   // event builders
   // -------------------------------------------------------------------------
   function automatic bit [31:0] tag_word(input bit [15:0] tag, input bit [5:0] kind,
                                          input bit [7:0] num);
      return {tag, 2'($urandom_range(3)), kind, num};
   endfunction

   function automatic bit [5:0] plain_type();
      bit [5:0] k;
      k = 6'($urandom_range(63));
      while (k == TYPE_FRAGMENT || k == TYPE_FRAGMENT_B || k == TYPE_COMPOSITE)
         k = 6'($urandom_range(63));
      return k;
   endfunction

   function automatic void add_plain_bank(ref word_queue_type q, input bit [15:0] tag,
                                          input bit [7:0] num, input int data_len);
      q.push_back(32'(data_len + 1));
      q.push_back(tag_word(tag, plain_type(), num));
      repeat (data_len) q.push_back($urandom());
   endfunction

   // header, tagsegment, inner bank header, data
   function automatic void add_composite_bank(ref word_queue_type q, input bit [15:0] tag,
                                              input bit [7:0] num, input int seg_words,
                                              input int data_len);
      q.push_back(32'(4 + seg_words + data_len));
      q.push_back(tag_word(tag, TYPE_COMPOSITE, num));
      q.push_back({16'($urandom()), 16'(seg_words)});
      repeat (seg_words) q.push_back($urandom());
      q.push_back(32'(data_len + 1));
      q.push_back(tag_word(16'($urandom()), plain_type(), 8'($urandom())));
      repeat (data_len) q.push_back($urandom());
   endfunction

   function automatic void add_fragment(ref word_queue_type q, input bit [15:0] tag,
                                        input bit [7:0] num, input word_queue_type contents);
      q.push_back(32'(contents.size() + 1));
      q.push_back(tag_word(tag, $urandom_range(1) ? TYPE_FRAGMENT : TYPE_FRAGMENT_B, num));
      foreach (contents[i]) q.push_back(contents[i]);
   endfunction

   // random words with some header-like ones mixed in
   function automatic void build_noise_event(ref word_queue_type words);
      bit [5:0] kinds[4];
      kinds = '{TYPE_FRAGMENT, TYPE_FRAGMENT_B, TYPE_COMPOSITE, 6'($urandom_range(63))};
      repeat ($urandom_range(1, 12)) begin
         case ($urandom_range(3))
            0: words.push_back(tag_word(search_cfg.fragment_tag, kinds[$urandom_range(3)],
                                        search_cfg.fragment_number));
            1: words.push_back(tag_word(search_cfg.bank_tag, kinds[$urandom_range(3)],
                                        search_cfg.bank_number));
            2: words.push_back(32'($urandom_range(0, 4)));
            default: words.push_back($urandom());
         endcase
      end
   endfunction

   // Mostly well-formed events: decoys at the top, then the sought fragment with
   // decoy banks and the sought bank. Some get a bad length word or are cut short.
   function automatic void build_random_event(ref word_queue_type words);
      word_queue_type body;
      word_queue_type inner;
      int      start;
      int      total;
      bit [7:0] num;
      words.delete();
      if ($urandom_range(9) == 0) begin
         build_noise_event(words);
         return;
      end
      repeat ($urandom_range(0, 2)) begin
         case ($urandom_range(2))
            0: add_plain_bank(body, 16'($urandom()), 8'($urandom()), $urandom_range(0, 4));
            1: begin
               inner.delete();
               repeat ($urandom_range(0, 2))
                  add_plain_bank(inner, 16'($urandom()), 8'($urandom()), $urandom_range(0, 3));
               if (!search_cfg.match_any_fragment_number && $urandom_range(1))
                  add_fragment(body, search_cfg.fragment_tag,
                               search_cfg.fragment_number ^ 8'($urandom_range(1, 255)), inner);
               else
                  add_fragment(body, search_cfg.fragment_tag ^ 16'($urandom_range(1, 65535)),
                               8'($urandom()), inner);
            end
            // a bank with the sought tag outside any fragment must be stepped over
            default: add_plain_bank(body, search_cfg.bank_tag, search_cfg.bank_number,
                                    $urandom_range(0, 3));
         endcase
      end
      if ($urandom_range(99) < 85) begin
         inner.delete();
         repeat ($urandom_range(0, 2)) begin
            if ($urandom_range(1))
               add_plain_bank(inner, search_cfg.bank_tag,
                              search_cfg.bank_number ^ 8'($urandom_range(1, 255)),
                              $urandom_range(0, 3));
            else
               add_plain_bank(inner, search_cfg.bank_tag ^ 16'($urandom_range(1, 65535)),
                              search_cfg.bank_number, $urandom_range(0, 3));
         end
         if ($urandom_range(99) < 80) begin
            start = inner.size();
            if ($urandom_range(99) < 55) begin
               add_plain_bank(inner, search_cfg.bank_tag, search_cfg.bank_number,
                              $urandom_range(0, 5));
               if ($urandom_range(9) == 0) inner[start] = 32'($urandom_range(0, 2));
            end else begin
               add_composite_bank(inner, search_cfg.bank_tag, search_cfg.bank_number,
                                  $urandom_range(0, 3), $urandom_range(0, 4));
               if ($urandom_range(9) == 0) inner[start] = 32'($urandom_range(0, 5));
               if ($urandom_range(19) == 0) inner[start + 2][15:0] = 16'($urandom());
            end
         end
         if ($urandom_range(1))
            add_plain_bank(inner, 16'($urandom()), 8'($urandom()), $urandom_range(0, 2));
         num = search_cfg.match_any_fragment_number ? 8'($urandom())
                                                    : search_cfg.fragment_number;
         add_fragment(body, search_cfg.fragment_tag, num, inner);
      end
      if ($urandom_range(1))
         add_plain_bank(body, 16'($urandom()), 8'($urandom()), $urandom_range(0, 2));
      total = body.size() + 2;
      case ($urandom_range(29))
         0, 1, 2: words.push_back(32'($urandom_range(0, total + 1)));
         3:       words.push_back($urandom());
         default: words.push_back(32'(total - 1));
      endcase
      words.push_back($urandom());
      foreach (body[i]) words.push_back(body[i]);
      if ($urandom_range(99) < 15) begin
         start = $urandom_range(1, words.size());
         while (words.size() > start) void'(words.pop_back());
      end
   endfunction

   // -------------------------------------------------------------------------
   // tests
   // -------------------------------------------------------------------------
   // a lone last word, with an all-ones length that wraps to zero words
   task automatic test_early_end();
      send_event('{32'hffff_ffff});
   endtask

   // unmapped indexes must leave every register alone
   task automatic test_unmapped_registers();
      for (int i = CSR_BANK_NUMBER + 1; i <= CSR_LAST_INDEX; i++)
         write_csr(CSR_INDEX_BITS'(i), $urandom());
   endtask

   task automatic test_plain_bank();
      send_event('{32'd6, 32'd0, 32'd4,
                   {16'hffff, 2'b11, TYPE_FRAGMENT, 8'hff},
                   32'd2, {16'hffff, 2'b11, 6'h01, 8'hff}, 32'hffff_ffff});
   endtask

   // composite bank: tagsegment of no words, inner pad taken off the count
   task automatic test_composite_bank();
      send_event('{32'd9, $urandom(), 32'd8,
                   {16'hffff, 2'b00, TYPE_FRAGMENT_B, 8'hff},
                   32'd5, {16'hffff, 2'b01, TYPE_COMPOSITE, 8'hff},
                   {16'hffff, 16'd0}, 32'd1, {16'h0000, 2'b11, 6'h01, 8'h00}, $urandom()});
   endtask

   // all-ones length gives a step of zero, the walk cannot advance
   task automatic test_zero_step();
      send_event('{32'd3, 32'd0, 32'hffff_ffff, {16'h1234, 2'b00, 6'h01, 8'h00}});
   endtask

   // fragment with two words or fewer cannot hold a bank
   task automatic test_short_fragment();
      send_event('{32'd3, 32'd0, 32'd1, {16'hffff, 2'b00, TYPE_FRAGMENT, 8'hff}});
   endtask

   // a length of zero makes the tag word the next length word; then a bank
   // with length zero clamps its byte count
   task automatic test_step_of_one();
      send_event('{32'd6, 32'd0, 32'd0, {16'h0000, 2'b00, 6'h01, 8'h00},
                   {16'hffff, 2'b00, TYPE_FRAGMENT, 8'hff},
                   32'd0, {16'hffff, 2'b10, 6'h02, 8'hff}});
   endtask

   task automatic test_random_events(input int word_budget, input int s_pct, input int r_pct);
      word_queue_type words;
      int      sent;
      sent          = 0;
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      while (sent < word_budget) begin
         build_random_event(words);
         send_event(words);
         sent += words.size();
      end
      settle();
   endtask

   // -------------------------------------------------------------------------
   // sequence
   // -------------------------------------------------------------------------
   initial begin : main
      cfg_type c;
      clear_walk();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 20;
      recv_idle_pct = 61;
      // registers still at reset
      test_early_end();
      settle();

      // high extreme on every tag and number register
      c = '0;
      c.fragment_tag    = 16'hffff;
      c.fragment_number = 8'hff;
      c.bank_tag        = 16'hffff;
      c.bank_number     = 8'hff;
      load_config(c);
      test_unmapped_registers();
      test_plain_bank();
      test_composite_bank();
      test_zero_step();
      test_short_fragment();
      test_step_of_one();
      settle();

      c = cfg_type'({$urandom(), $urandom()});
      c.match_any_fragment_number = 1'b0;
      load_config(c);
      test_random_events(320, 20, 61);

      // low extreme, match on tag alone
      c = '0;
      c.match_any_fragment_number = 1'b1;
      load_config(c);
      test_random_events(320, 61, 20);

      c = cfg_type'({$urandom(), $urandom()});
      load_config(c);
      test_random_events(320, 0, 0);

      if (lookup_errors == 0 && pending_lookups.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin : watchdog
      #1_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

@@ tagged_bank_locator.f @@
hdl/tbl_pkg.sv
hdl/tbl_word_reg.sv
hdl/tbl_search.sv
hdl/tagged_bank_locator.sv
dv/tb_tagged_bank_locator.sv
